/* rtl/multichannel_fir_filter_macros.svh */
// Assertion macros for the multichannel FIR filter.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef MULTICHANNEL_FIR_FILTER_MACROS_SVH
`define MULTICHANNEL_FIR_FILTER_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define MCFIR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define MCFIR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MCFIR_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define MCFIR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/mcfir_pkg.sv */
// Package for the multichannel FIR filter: request and result types and fixed constants.
// No dependencies; used by multichannel_fir_filter and its testbench.
package mcfir_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int FRAC_BITS = SAMPLE_W - 1;
    localparam int TAP_FW    = 5;

    localparam logic FUNC_COEF   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    typedef struct packed {
        logic                       func;
        logic                       channel;
        logic [TAP_FW-1:0]          tap;
        logic signed [SAMPLE_W-1:0] value;
        logic                       frame_last;
    } t_in_req;

    typedef struct packed {
        logic                       out_channel;
        logic signed [SAMPLE_W-1:0] filtered;
    } t_out_rsp;

endpackage

/* rtl/multichannel_fir_filter.sv */
// Top level of the multichannel FIR filter: sample and coefficient memories with one
// shared multiply-accumulate unit. Depends on mcfir_pkg and multichannel_fir_filter_macros.svh.
//
// Usage. The input channel (i_in_valid, o_in_stall, i_in_req) carries two kinds of request.
// A coefficient request (func = write coefficient) stores one tap of one channel and leaves
// the block idle; it produces no result. A sample request writes the sample into its channel's
// circular queue and then walks all TAPS products, oldest sample against tap 0, through one
// multiplier and one accumulator. The result (channel and rounded, saturated Q1.15 value)
// appears on the output channel (o_out_valid, i_out_stall, o_out_rsp), and no further
// request is taken until the result has been loaded into the output register. The time a
// sample occupies the block is set by the single read port of each memory: one tap is read
// per cycle, plus the read, multiply, accumulate and rounding stages.
// A sample request flagged frame_last advances the shared write index for all channels.
// Requests naming a channel at or above CHANNELS are accepted and dropped.
//
// After reset the block clears CHANNELS * 2**ceil(log2(TAPS)) entries of the sample memory,
// one entry per cycle, with o_in_stall held high. Coefficients are not cleared and must be
// written before use. The result sits in an output register; while the receiver stalls it
// the block finishes the next sample and then waits to hand it over.
module multichannel_fir_filter #(
    parameter int TAPS     = 32,
    parameter int CHANNELS = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mcfir_pkg::t_in_req  i_in_req,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mcfir_pkg::t_out_rsp o_out_rsp
);

`include "multichannel_fir_filter_macros.svh"

    // Index, channel and address widths. Each memory is laid out as {channel, tap index}.
    localparam int IDX_W     = $clog2(TAPS);
    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ADDR_W    = CH_W + IDX_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam int CLR_N     = CHANNELS << IDX_W;
    localparam int SW        = mcfir_pkg::SAMPLE_W;
    localparam int PROD_W    = 2 * SW;
    // Worst-case sum magnitude is TAPS * 2**(2*SW-2), so this width never wraps.
    localparam int ACC_W     = PROD_W + IDX_W;

    localparam logic [IDX_W-1:0]         TAPS_LAST = IDX_W'(TAPS - 1);
    localparam logic [ADDR_W-1:0]        CLR_LAST  = ADDR_W'(CLR_N - 1);
    localparam logic signed [ACC_W-1:0]  RND_HALF  = ACC_W'(2 ** (mcfir_pkg::FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0]  SAT_MAX   = ACC_W'(2 ** (SW - 1) - 1);
    localparam logic signed [ACC_W-1:0]  SAT_MIN   = -(ACC_W'(2 ** (SW - 1)));

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    t_state                     r_state;
    logic [ADDR_W-1:0]          r_clr;
    logic [IDX_W-1:0]           r_wi;
    logic [CH_W-1:0]            r_ch;
    logic [IDX_W-1:0]           r_k;
    logic [IDX_W-1:0]           r_pos;
    logic                       r_issue;
    logic                       r_rd_v;
    logic                       r_mul_v;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic                       r_out_v;
    mcfir_pkg::t_out_rsp        r_out;

    logic signed [SW-1:0]       smp_mem  [MEM_DEPTH];
    logic signed [SW-1:0]       coef_mem [MEM_DEPTH];
    logic signed [SW-1:0]       r_smp_q;
    logic signed [SW-1:0]       r_coef_q;

    logic                       in_acc;
    logic                       ch_ok;
    logic [CH_W-1:0]            in_ch;
    logic                       smp_req;
    logic                       coef_req;
    logic [IDX_W-1:0]           wi_inc;
    logic [IDX_W-1:0]           pos_inc;
    logic                       smp_we;
    logic [ADDR_W-1:0]          smp_waddr;
    logic signed [SW-1:0]       smp_wdata;
    logic                       rd_en;
    logic                       out_free;
    logic signed [ACC_W-1:0]    rnd_sum;
    logic signed [ACC_W-1:0]    rnd_q;
    logic signed [SW-1:0]       sat_val;

    // A request is taken only in the idle state; out-of-range channels are dropped.
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign in_ch      = CH_W'(i_in_req.channel);
    assign ch_ok      = (32'(i_in_req.channel) < CHANNELS);
    assign smp_req    = in_acc && ch_ok && (i_in_req.func == mcfir_pkg::FUNC_SAMPLE);
    assign coef_req   = in_acc && ch_ok && (i_in_req.func == mcfir_pkg::FUNC_COEF)
                        && (32'(i_in_req.tap) < TAPS);

    // Circular index arithmetic modulo TAPS.
    assign wi_inc  = (r_wi == TAPS_LAST) ? '0 : r_wi + 1'b1;
    assign pos_inc = (r_pos == TAPS_LAST) ? '0 : r_pos + 1'b1;

    // The sample memory write port serves the clearing pass and new samples.
    always_comb begin
        if (r_state == S_CLEAR) begin
            smp_we    = 1'b1;
            smp_waddr = r_clr;
            smp_wdata = '0;
        end else begin
            smp_we    = smp_req;
            smp_waddr = {in_ch, r_wi};
            smp_wdata = i_in_req.value;
        end
    end

    assign rd_en = (r_state == S_RUN) && r_issue;

    always_ff @(posedge i_clk) begin
        if (smp_we) begin
            smp_mem[smp_waddr] <= smp_wdata;
        end
        if (rd_en) begin
            r_smp_q <= smp_mem[{r_ch, r_pos}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (coef_req) begin
            coef_mem[{in_ch, IDX_W'(i_in_req.tap)}] <= i_in_req.value;
        end
        if (rd_en) begin
            r_coef_q <= coef_mem[{r_ch, r_k}];
        end
    end

    // Round half up at the binary point, then saturate to the sample range.
    assign rnd_sum = r_acc + RND_HALF;
    assign rnd_q   = rnd_sum >>> mcfir_pkg::FRAC_BITS;
    always_comb begin
        if (rnd_q > SAT_MAX) begin
            sat_val = SAT_MAX[SW-1:0];
        end else if (rnd_q < SAT_MIN) begin
            sat_val = SAT_MIN[SW-1:0];
        end else begin
            sat_val = rnd_q[SW-1:0];
        end
    end

    assign out_free = !r_out_v || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_wi    <= '0;
            r_issue <= 1'b0;
            r_rd_v  <= 1'b0;
            r_mul_v <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            // In the done state the load below decides the output valid on its own.
            if (r_out_v && !i_out_stall && (r_state != S_DONE)) begin
                r_out_v <= 1'b0;
            end
            r_rd_v  <= rd_en;
            r_mul_v <= r_rd_v;
            if (r_rd_v) begin
                r_prod <= r_coef_q * r_smp_q;
            end
            if (r_mul_v) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == CLR_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (smp_req) begin
                        // The window starts just after the new sample, so the
                        // newest sample meets the last tap.
                        r_ch    <= in_ch;
                        r_pos   <= wi_inc;
                        r_k     <= '0;
                        r_issue <= 1'b1;
                        r_acc   <= '0;
                        r_state <= S_RUN;
                        if (i_in_req.frame_last) begin
                            r_wi <= wi_inc;
                        end
                    end
                end
                S_RUN: begin
                    if (r_issue) begin
                        if (r_k == TAPS_LAST) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_k   <= r_k + 1'b1;
                            r_pos <= pos_inc;
                        end
                    end else if (!r_rd_v && !r_mul_v) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out.out_channel <= r_ch[0];
                        r_out.filtered    <= sat_val;
                        r_out_v           <= 1'b1;
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_rsp   = r_out;

    // A sample request always occupies the block on the following cycle.
    `MCFIR_ASSERT_NEXT(a_sample_busy, i_clk, i_rst_n, smp_req, o_in_stall)
    // The write index moves only on a sample request flagged as the last of a frame.
    `MCFIR_ASSERT_NEXT(a_wi_hold, i_clk, i_rst_n, !(smp_req && i_in_req.frame_last), $stable(r_wi))
    // No result is presented while the sample memory is being cleared.
    `MCFIR_ASSERT_NOW(a_clear_quiet, i_clk, i_rst_n, r_state == S_CLEAR, !o_out_valid)

endmodule

/* tb/tb_multichannel_fir_filter.sv */
`timescale 1ns / 100ps
// Self-checking testbench for multichannel_fir_filter: coefficient and sample requests
// are driven through the input handshake, and every result is compared with a built-in
// predictor of the filter. Depends on mcfir_pkg and the multichannel_fir_filter RTL.
module tb_multichannel_fir_filter;

    localparam int NUM_TAPS     = 32;
    localparam int NUM_CHANNELS = 2;
    localparam int REQ_W        = $bits(mcfir_pkg::t_in_req);
    // This many cycles without any handshake on either side means the block has hung.
    // The long receiver hold-off below stays well under this figure.
    localparam int HANG_LIMIT   = 5000;
    // Cycles to keep watching the output once nothing is expected any more.
    localparam int DRAIN_CYCLES = 100;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    mcfir_pkg::t_in_req  i_in_req;
    logic                o_out_valid;
    logic                i_out_stall;
    mcfir_pkg::t_out_rsp o_out_rsp;

    multichannel_fir_filter #(
        .TAPS     (NUM_TAPS),
        .CHANNELS (NUM_CHANNELS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp)
    );

    // Mirror of the filter state. Each channel keeps a history of 2 * TAPS samples so
    // that the window of the newest TAPS samples is always contiguous: a sample lands at
    // the write index and again TAPS entries higher.
    logic signed [mcfir_pkg::SAMPLE_W-1:0] sample_hist [NUM_CHANNELS][2*NUM_TAPS]
        = '{default: '0};
    logic signed [mcfir_pkg::SAMPLE_W-1:0] tap_coef    [NUM_CHANNELS][NUM_TAPS]
        = '{default: '0};
    logic        [mcfir_pkg::TAP_FW-1:0]   hist_wr_idx = '0;

    // Filter outputs that the predictor has produced and the block has not yet delivered.
    mcfir_pkg::t_out_rsp filtered_expect_q[$];

    int err_count     = 0;
    int send_idle_pct = 0;  // chance in percent that the sender idles a given cycle
    int stall_pct     = 0;  // chance in percent that the receiver stalls a given cycle
    int hold_off_left = 0;  // cycles of forced receiver stall still to go

    // 100 MHz clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Predictor. A coefficient request only updates the tap set. A sample request writes
    // the history, forms the exact 64-bit sum of products over the window (oldest sample
    // against tap 0), rounds half up at bit 15 and saturates to Q1.15. The frame_last
    // flag of a sample request then steps the shared write index.
    task automatic predict_filter(input mcfir_pkg::t_in_req req);
        longint              acc;
        int                  ch;
        int                  wi;
        mcfir_pkg::t_out_rsp rsp;
        ch = int'(req.channel);
        wi = int'(hist_wr_idx);
        if (req.func == mcfir_pkg::FUNC_COEF) begin
            tap_coef[ch][req.tap] = req.value;
            return;
        end
        sample_hist[ch][wi]            = req.value;
        sample_hist[ch][wi + NUM_TAPS] = req.value;
        acc = 0;
        for (int k = 0; k < NUM_TAPS; k++) begin
            acc += longint'(tap_coef[ch][k]) * longint'(sample_hist[ch][wi + 1 + k]);
        end
        acc = (acc + (longint'(1) <<< (mcfir_pkg::FRAC_BITS - 1)))
              >>> mcfir_pkg::FRAC_BITS;
        if (acc > 32767) begin
            acc = 32767;
        end else if (acc < -32768) begin
            acc = -32768;
        end
        rsp.out_channel = req.channel;
        rsp.filtered    = acc[mcfir_pkg::SAMPLE_W-1:0];
        filtered_expect_q.push_back(rsp);
        if (req.frame_last) begin
            hist_wr_idx = hist_wr_idx + 1'b1;  // wraps modulo TAPS by its width
        end
    endtask

    function automatic mcfir_pkg::t_in_req make_req(input logic func, input int ch,
                                                    input int tap, input int value,
                                                    input int last);
        mcfir_pkg::t_in_req r;
        r.func       = func;
        r.channel    = ch[0];
        r.tap        = tap[mcfir_pkg::TAP_FW-1:0];
        r.value      = value[mcfir_pkg::SAMPLE_W-1:0];
        r.frame_last = last[0];
        return r;
    endfunction

    // Offers one request, with random idle cycles before it, and returns at the edge
    // where it is accepted. Valid is left high afterwards so that back-to-back requests
    // never see valid lowered and raised within one time step; the next call or the end
    // of the stimulus decides what valid does next.
    task automatic send_req(input mcfir_pkg::t_in_req req);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            i_in_req   <= mcfir_pkg::t_in_req'(REQ_W'($urandom));
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= req;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        predict_filter(req);
    endtask

    // Random request. Most are samples, since only samples exercise the datapath; the
    // rest rewrite a random tap. Full-scale values are favored so that saturation on both
    // sides shows up regularly among the random sums.
    function automatic mcfir_pkg::t_in_req random_req();
        int   value;
        logic func;
        func = ($urandom_range(99) < 80) ? mcfir_pkg::FUNC_SAMPLE : mcfir_pkg::FUNC_COEF;
        case ($urandom_range(9))
            0: value = 32767;
            1: value = -32768;
            2: value = $urandom_range(15) - 8;
            default: value = $urandom;
        endcase
        return make_req(func, $urandom_range(1), $urandom_range(NUM_TAPS - 1), value,
                        $urandom_range(1));
    endfunction

    // Every tap of both channels is written before any sample is filtered, since the
    // coefficient memory is not cleared by reset. The chosen sets make the directed
    // cases easy to follow: channel 0 listens to its newest sample only, channel 1 to
    // its two newest, each with the most negative coefficient.
    task automatic test_load_taps();
        for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            for (int t = 0; t < NUM_TAPS; t++) begin
                if (t == NUM_TAPS - 1 || (ch == 1 && t == NUM_TAPS - 2)) begin
                    send_req(make_req(mcfir_pkg::FUNC_COEF, ch, t, -32768, 0));
                end else begin
                    send_req(make_req(mcfir_pkg::FUNC_COEF, ch, t, 0, 0));
                end
            end
        end
    endtask

    // Directed corner cases: positive saturation from a single full-scale product,
    // the largest unsaturated negative product, rounding half up in both signs, negative
    // saturation from two products, a frame_last on a coefficient request (must not move
    // the index) and the extreme positive coefficient.
    task automatic test_round_and_saturate();
        send_req(make_req(mcfir_pkg::FUNC_SAMPLE, 0, 0, -32768, 0));
        send_req(make_req(mcfir_pkg::FUNC_SAMPLE, 0, 31, 32767, 0));
        send_req(make_req(mcfir_pkg::FUNC_SAMPLE, 0, 0, 0, 0));
        // A coefficient of one half on the newest sample turns odd samples into ties.
        send_req(make_req(mcfir_pkg::FUNC_COEF, 0, NUM_TAPS - 1, 16384, 1));
        send_req(make_req(mcfir_pkg::FUNC_SAMPLE, 0, 0, 1, 0));
        send_req(make_req(mcfir_pkg::FUNC_SAMPLE, 0, 0, -1, 0));
        send_req(make_req(mcfir_pkg::FUNC_SAMPLE, 0, 0, 3, 0));
        send_req(make_req(mcfir_pkg::FUNC_SAMPLE, 0, 0, -3, 0));
        // Two full-scale samples in consecutive frames drive channel 1 below -1.0.
        send_req(make_req(mcfir_pkg::FUNC_SAMPLE, 1, 0, 32767, 1));
        send_req(make_req(mcfir_pkg::FUNC_SAMPLE, 1, 31, 32767, 1));
        send_req(make_req(mcfir_pkg::FUNC_COEF, 0, 0, 32767, 0));
        send_req(make_req(mcfir_pkg::FUNC_SAMPLE, 0, 21, -32768, 1));
        send_req(make_req(mcfir_pkg::FUNC_SAMPLE, 1, 10, 21845, 1));
        send_req(make_req(mcfir_pkg::FUNC_SAMPLE, 0, 0, -21846, 0));
    endtask

    // Random traffic under one idling profile. Each round is, two times in three, a
    // frame (channel 0 then channel 1 with frame_last on the last one), the way the
    // block is used; otherwise it is one arbitrary request.
    task automatic test_random_traffic(input int idle_pct, input int stall_pct_arg,
                                       input int num_reqs);
        mcfir_pkg::t_in_req req;
        int                 sent;
        send_idle_pct = idle_pct;
        stall_pct     = stall_pct_arg;
        sent          = 0;
        while (sent < num_reqs) begin
            if ($urandom_range(2) != 0) begin
                for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
                    req            = random_req();
                    req.func       = mcfir_pkg::FUNC_SAMPLE;
                    req.channel    = ch[0];
                    req.frame_last = (ch == NUM_CHANNELS - 1);
                    send_req(req);
                    sent++;
                end
            end else begin
                send_req(random_req());
                sent++;
            end
        end
    endtask

    // The receiver holds off for a long stretch while the sender offers requests back
    // to back: the output register and the next finished sample fill the block, so it
    // must stall its input until the receiver lets go.
    task automatic test_output_backpressure();
        mcfir_pkg::t_in_req req;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_off_left = 500;
        for (int n = 0; n < 24; n++) begin
            req      = random_req();
            req.func = mcfir_pkg::FUNC_SAMPLE;
            send_req(req);
        end
    endtask

    // Receiver: random stalls, or a forced stall while a hold-off is counting down.
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_left > 0) begin
                i_out_stall <= 1'b1;
                hold_off_left--;
            end else begin
                i_out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Result checker: every accepted result is matched against the oldest prediction.
    always @(posedge i_clk) begin
        mcfir_pkg::t_out_rsp exp_rsp;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (filtered_expect_q.size() == 0) begin
                $error("unexpected result: out_channel %0d filtered %0d",
                       o_out_rsp.out_channel, $signed(o_out_rsp.filtered));
                err_count++;
            end else begin
                exp_rsp = filtered_expect_q.pop_front();
                if (o_out_rsp.out_channel !== exp_rsp.out_channel) begin
                    $error("out_channel mismatch: expected %0d, actual %0d",
                           exp_rsp.out_channel, o_out_rsp.out_channel);
                    err_count++;
                end
                if (o_out_rsp.filtered !== exp_rsp.filtered) begin
                    $error("filtered mismatch: expected %0d, actual %0d",
                           $signed(exp_rsp.filtered), $signed(o_out_rsp.filtered));
                    err_count++;
                end
            end
        end
    end

    // Hang detection: cycles without a handshake on either side. The clearing pass
    // after reset is short compared with the limit.
    always @(posedge i_clk) begin
        int quiet_cycles;
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= HANG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_req   <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_load_taps();
        test_round_and_saturate();
        test_random_traffic(0, 0, 420);
        test_random_traffic(52, 0, 420);
        test_random_traffic(0, 52, 420);
        test_random_traffic(33, 33, 420);
        test_output_backpressure();

        // The last request was accepted at this edge; stop offering and let the
        // outstanding results drain, then watch a while longer for stray ones.
        i_in_valid <= 1'b0;
        while (filtered_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/mcfir_pkg.sv
rtl/multichannel_fir_filter.sv
tb/tb_multichannel_fir_filter.sv
